>>> hdl/ifir_pkg.sv
package ifir_pkg;

  localparam int TAP_COUNT = 23;
  localparam int TAP_W     = 14;
  localparam int TAP_IDX_W = $clog2(TAP_COUNT);
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  localparam int ACC_W     = 32;
  localparam int ACC_SHIFT = 16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic                 shift;
    logic                 prod_en;
    logic [TAP_IDX_W-1:0] tap_idx;
    logic                 load_out;
  } ifir_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;
  } ifir_stat_t;

  // symmetric low-pass coefficients, tap 0 weights the newest sample
  function automatic logic signed [TAP_W-1:0] tap_coef(input logic [TAP_IDX_W-1:0] idx);
    logic signed [TAP_W-1:0] c;
    case (idx)
      5'd0, 5'd22:  c = 14'sd238;
      5'd1, 5'd21:  c = 14'sd42;
      5'd2, 5'd20:  c = -14'sd346;
      5'd3, 5'd19:  c = -14'sd1017;
      5'd4, 5'd18:  c = -14'sd1728;
      5'd5, 5'd17:  c = -14'sd2051;
      5'd6, 5'd16:  c = -14'sd1537;
      5'd7, 5'd15:  c = 14'sd35;
      5'd8, 5'd14:  c = 14'sd2473;
      5'd9, 5'd13:  c = 14'sd5159;
      5'd10, 5'd12: c = 14'sd7256;
      5'd11:        c = 14'sd8049;
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/integer_fir_lowpass_23tap.sv
// integer low-pass fir filter, 23 fixed symmetric taps
//
// input channel s_axis: one beat carries one signed sample in tdata[15:0];
// only the low SAMPLE_WIDTH bits are used, read as a signed value
// output channel m_axis: one beat carries one filtered sample in tdata[15:0],
// the tap-weighted sum of the last 23 samples shifted arithmetically right 16
//
// every input beat yields exactly one output beat, in order
// one shared multiplier walks the 23 taps, one tap per cycle, followed by a
// flush state that accumulates the last product and a store state that loads
// the output register once it is free; a new sample is accepted only after
// the previous result has been loaded into the output register
//
// the output register holds a finished result until the receiver takes it;
// the next sample may be accepted and computed meanwhile, and only its final
// store waits for the output register to free up
//
// reset (rst, synchronous, active high) clears the delay line to zero,
// returns the controller to idle and drops m_axis_tvalid
module integer_fir_lowpass_23tap
  import ifir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] filtered
);

  ifir_cmd_t               cmd;
  ifir_stat_t              stat;
  logic signed [OUT_W-1:0] filtered;

  // sequencer: accept, tap walk, flush, store
  ifir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // delay line, multiply-accumulate and output register
  ifir_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .sample    (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .filtered  (filtered)
  );

  assign m_axis_tdata = filtered;

endmodule

>>> hdl/ifir_ctrl.sv
module ifir_ctrl
  import ifir_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ifir_stat_t stat,
  output ifir_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_STORE = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [TAP_IDX_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    cmd.shift    = 1'b0;
    cmd.prod_en  = 1'b0;
    cmd.tap_idx  = cnt;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.shift  = 1'b1;
          cnt_next   = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.prod_en = 1'b1;
        if (cnt == TAP_IDX_W'(TAP_COUNT - 1)) begin
          state_next = ST_FLUSH;
        end else begin
          cnt_next = cnt + TAP_IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        // last product enters the accumulator
        state_next = ST_STORE;
      end
      ST_STORE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/ifir_dp.sv
module ifir_dp
  import ifir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [IN_W-1:0]         sample,
  input  ifir_cmd_t               cmd,
  output ifir_stat_t              stat,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] filtered
);

  localparam int PROD_W = SAMPLE_WIDTH + TAP_W;

  logic signed [SAMPLE_WIDTH-1:0] dly [TAP_COUNT];
  logic signed [PROD_W-1:0]       prod;
  logic                           prod_vld;
  logic signed [ACC_W-1:0]        acc;
  logic signed [SAMPLE_WIDTH-1:0] dly_sel;
  logic signed [TAP_W-1:0]        coef_sel;

  assign dly_sel  = dly[cmd.tap_idx];
  assign coef_sel = tap_coef(cmd.tap_idx);

  // delay line, newest sample at index 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        dly[i] <= '0;
      end
    end else if (cmd.shift) begin
      dly[0] <= $signed(sample[SAMPLE_WIDTH-1:0]);
      for (int i = 1; i < TAP_COUNT; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  // multiply stage then accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.prod_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod <= PROD_W'(dly_sel) * PROD_W'(coef_sel);
    end
    if (cmd.shift) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered <= acc[ACC_SHIFT +: OUT_W];
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule
